/* src/slmc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slmc_pkg
// Shared types and constants of the segmented LRU mapping cache.
// ----------------------------------------------------------------------------
package slmc_pkg;

    localparam int SLMC_ENTRIES = 64;

    typedef enum logic [1:0] {
        OP_GET    = 2'd0,
        OP_ADD    = 2'd1,
        OP_UPDATE = 2'd2,
        OP_EVICT  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_NONE,
        K_TOUCH,
        K_PROMOTE,
        K_INSERT,
        K_REWRITE,
        K_DROP
    } t_kind;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_UPDATE,
        S_RESP
    } t_state;

    // What one entry reports to the sequencer during the search pass.
    typedef struct packed {
        logic match;
        logic free;
        logic lru_prob;
        logic lru_prot;
    } t_hits;

endpackage
`default_nettype wire

/* src/slmc_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slmc request and response channels
// Valid/ready channels carrying a request word and a response word.
// ----------------------------------------------------------------------------
interface slmc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] page_key;
    logic [31:0] page_value;

    modport source (output valid, op, page_key, page_value, input ready);
    modport sink   (input valid, op, page_key, page_value, output ready);
endinterface

interface slmc_rsp_if;
    logic        valid;
    logic        ready;
    logic        failed;
    logic [31:0] out_value;
    logic [31:0] out_key;
    logic        out_dirty;
    logic        probation_full;

    modport source (output valid, failed, out_value, out_key, out_dirty, probation_full,
                    input ready);
    modport sink   (input valid, failed, out_value, out_key, out_dirty, probation_full,
                     output ready);
endinterface
`default_nettype wire

/* src/slmc_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slmc_store
// Entry memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module slmc_store #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int WW    = 73
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [WW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [WW-1:0] o_rd_data
);
    logic [WW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule
`default_nettype wire

/* src/slmc_entry_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slmc_entry_unit
// Compare and rank update logic applied to one entry per cycle.
// ----------------------------------------------------------------------------
module slmc_entry_unit
    import slmc_pkg::*;
#(
    parameter int IW = 6,
    parameter int CW = 7
) (
    input  wire logic [IW-1:0] i_idx,
    input  wire logic          i_valid,
    input  wire logic          i_prot,
    input  wire logic          i_dirty,
    input  wire logic [IW-1:0] i_rank,
    input  wire logic [31:0]   i_key,
    input  wire logic [31:0]   i_value,
    input  wire logic [31:0]   i_req_key,
    input  wire logic [31:0]   i_req_value,
    input  wire logic [CW-1:0] i_prob_cnt,
    input  wire logic [CW-1:0] i_prot_cnt,
    input  wire t_kind         i_kind,
    input  wire logic [IW-1:0] i_tgt,
    input  wire logic [IW-1:0] i_tgt_rank,
    input  wire logic [IW-1:0] i_aux,
    input  wire logic          i_demote,
    output t_hits              o_hits,
    output logic               o_valid,
    output logic               o_prot,
    output logic               o_dirty,
    output logic [IW-1:0]      o_rank,
    output logic [31:0]        o_key,
    output logic [31:0]        o_value
);
    logic [CW-1:0] rank_w;
    logic          is_tgt;

    assign rank_w = CW'(i_rank);
    assign is_tgt = (i_idx == i_tgt);

    always_comb begin
        o_hits.match    = i_valid && (i_key == i_req_key);
        o_hits.free     = !i_valid;
        o_hits.lru_prob = i_valid && !i_prot && (i_prob_cnt != '0)
                          && (rank_w == i_prob_cnt - CW'(1));
        o_hits.lru_prot = i_valid && i_prot && (i_prot_cnt != '0)
                          && (rank_w == i_prot_cnt - CW'(1));
    end

    always_comb begin
        o_valid = i_valid;
        o_prot  = i_prot;
        o_dirty = i_dirty;
        o_rank  = i_rank;
        o_key   = i_key;
        o_value = i_value;
        unique case (i_kind)
            K_TOUCH: begin
                if (is_tgt) begin
                    o_rank = '0;
                end else if (i_valid && i_prot && i_rank < i_tgt_rank) begin
                    o_rank = i_rank + IW'(1);
                end
            end
            K_PROMOTE: begin
                if (is_tgt) begin
                    o_prot = 1'b1;
                    o_rank = '0;
                end else if (i_demote && i_idx == i_aux) begin
                    // The protected LRU entry drops back to probationary MRU.
                    o_prot = 1'b0;
                    o_rank = '0;
                end else if (i_valid && i_prot) begin
                    o_rank = i_rank + IW'(1);
                end else if (i_valid) begin
                    if (i_demote) begin
                        if (i_rank < i_tgt_rank) begin
                            o_rank = i_rank + IW'(1);
                        end
                    end else if (i_rank > i_tgt_rank) begin
                        o_rank = i_rank - IW'(1);
                    end
                end
            end
            K_INSERT: begin
                if (is_tgt) begin
                    o_valid = 1'b1;
                    o_prot  = 1'b0;
                    o_dirty = 1'b0;
                    o_rank  = '0;
                    o_key   = i_req_key;
                    o_value = i_req_value;
                end else if (i_valid && !i_prot) begin
                    o_rank = i_rank + IW'(1);
                end
            end
            K_REWRITE: begin
                if (is_tgt) begin
                    o_value = i_req_value;
                    o_dirty = 1'b1;
                end
            end
            K_DROP: begin
                if (is_tgt) begin
                    o_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end
endmodule
`default_nettype wire

/* src/segmented_lru_mapping_cache_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// segmented_lru_mapping_cache_unit
// Segmented LRU cache of page mappings, handled one request word at a time.
// ----------------------------------------------------------------------------
// A request word occupies the block from the cycle in which it is taken until
// its response word is accepted: a pass over the entry memory that finds the
// key, a free slot and both LRU entries, the decision state S_DECIDE, a second
// pass that rewrites ranks and the target entry, and the response state, which
// waits for ready. Both passes go through the single read and write port of
// the memory and one shared per-entry compare/update unit. Operations that
// fail skip the second pass. After reset a clearing pass invalidates the
// memory before the first request word is taken.
module segmented_lru_mapping_cache_unit
    import slmc_pkg::*;
#(
    parameter int ENTRIES = SLMC_ENTRIES
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    slmc_req_if.sink    i_req,
    slmc_rsp_if.source  o_rsp
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int WW = 3 + IW + 64;
    localparam logic [CW-1:0] CAP  = CW'(ENTRIES / 2);
    localparam logic [CW-1:0] LAST = CW'(ENTRIES - 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt;
    logic          r_dv;
    logic [IW-1:0] r_didx;
    t_op           r_op;
    logic [31:0]   r_key, r_val;
    logic [CW-1:0] r_p_cnt, r_q_cnt;

    logic          r_m_found, r_f_found, r_lp_found, r_lq_found;
    logic [IW-1:0] r_m_idx, r_m_rank, r_f_idx, r_lp_idx, r_lq_idx;
    logic          r_m_prot;
    logic [31:0]   r_m_val, r_lp_key, r_lp_val;
    logic          r_lp_dirty;

    t_kind         r_kind;
    logic [IW-1:0] r_tgt, r_tgt_rank, r_aux;
    logic          r_demote;

    logic          r_failed, r_odirty, r_pfull;
    logic [31:0]   r_oval, r_okey;

    logic          wr_en, rd_en;
    logic [IW-1:0] wr_addr;
    logic [WW-1:0] wr_data, rd_data;
    logic          last_data;
    logic          go_update;

    logic          e_valid, e_prot, e_dirty;
    logic [IW-1:0] e_rank;
    logic [31:0]   e_key, e_value;
    t_hits         hits;
    logic          u_valid, u_prot, u_dirty;
    logic [IW-1:0] u_rank;
    logic [31:0]   u_key, u_value;

    assign {e_valid, e_prot, e_dirty, e_rank, e_key, e_value} = rd_data;
    assign last_data = r_dv && (r_didx == LAST[IW-1:0]);

    slmc_store #(.DEPTH(ENTRIES), .AW(IW), .WW(WW)) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_cnt[IW-1:0]),
        .o_rd_data (rd_data)
    );

    slmc_entry_unit #(.IW(IW), .CW(CW)) u_entry (
        .i_idx       (r_didx),
        .i_valid     (e_valid),
        .i_prot      (e_prot),
        .i_dirty     (e_dirty),
        .i_rank      (e_rank),
        .i_key       (e_key),
        .i_value     (e_value),
        .i_req_key   (r_key),
        .i_req_value (r_val),
        .i_prob_cnt  (r_p_cnt),
        .i_prot_cnt  (r_q_cnt),
        .i_kind      (r_kind),
        .i_tgt       (r_tgt),
        .i_tgt_rank  (r_tgt_rank),
        .i_aux       (r_aux),
        .i_demote    (r_demote),
        .o_hits      (hits),
        .o_valid     (u_valid),
        .o_prot      (u_prot),
        .o_dirty     (u_dirty),
        .o_rank      (u_rank),
        .o_key       (u_key),
        .o_value     (u_value)
    );

    // Whether the operation succeeds, known from the search results while in
    // S_DECIDE, before the decision registers are loaded.
    always_comb begin
        unique case (r_op)
            OP_GET:    go_update = r_m_found;
            OP_ADD:    go_update = (r_p_cnt < CAP) && !r_m_found && r_f_found;
            OP_UPDATE: go_update = r_m_found;
            OP_EVICT:  go_update = (r_p_cnt >= CAP) && r_lp_found;
            default:   go_update = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        wr_addr = r_didx;
        wr_data = {u_valid, u_prot, u_dirty, u_rank, u_key, u_value};
        unique case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_cnt[IW-1:0];
                wr_data = '0;
                if (r_cnt == LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                rd_en = (r_cnt < CW'(ENTRIES));
                if (last_data) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = go_update ? S_UPDATE : S_RESP;
            end
            S_UPDATE: begin
                rd_en = (r_cnt < CW'(ENTRIES));
                wr_en = r_dv;
                if (last_data) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (o_rsp.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Read pipeline bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_dv  <= 1'b0;
        end else begin
            r_dv <= rd_en;
            if (r_state == S_CLEAR || rd_en) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (r_state == S_IDLE || r_state == S_DECIDE) begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_didx <= r_cnt[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_cnt <= '0;
            r_q_cnt <= '0;
            r_kind  <= K_NONE;
        end else begin
            if (r_state == S_IDLE && i_req.valid) begin
                r_op       <= t_op'(i_req.op);
                r_key      <= i_req.page_key;
                r_val      <= i_req.page_value;
                r_kind     <= K_NONE;
                r_m_found  <= 1'b0;
                r_f_found  <= 1'b0;
                r_lp_found <= 1'b0;
                r_lq_found <= 1'b0;
            end
            if (r_state == S_SCAN && r_dv) begin
                // Keep the first entry of each kind, as the search order gives.
                if (hits.match && !r_m_found) begin
                    r_m_found <= 1'b1;
                    r_m_idx   <= r_didx;
                    r_m_prot  <= e_prot;
                    r_m_rank  <= e_rank;
                    r_m_val   <= e_value;
                end
                if (hits.free && !r_f_found) begin
                    r_f_found <= 1'b1;
                    r_f_idx   <= r_didx;
                end
                if (hits.lru_prob && !r_lp_found) begin
                    r_lp_found <= 1'b1;
                    r_lp_idx   <= r_didx;
                    r_lp_key   <= e_key;
                    r_lp_val   <= e_value;
                    r_lp_dirty <= e_dirty;
                end
                if (hits.lru_prot && !r_lq_found) begin
                    r_lq_found <= 1'b1;
                    r_lq_idx   <= r_didx;
                end
            end
            if (r_state == S_SCAN && last_data) begin
                r_failed   <= 1'b1;
                r_oval     <= '0;
                r_okey     <= '0;
                r_odirty   <= 1'b0;
                r_pfull    <= (r_p_cnt >= CAP);
                r_demote   <= 1'b0;
                r_tgt      <= r_m_idx;
                r_tgt_rank <= r_m_rank;
                r_aux      <= r_lq_idx;
                // The capture registers settle on this edge, so the decision
                // is made in the next state, S_DECIDE.
            end
            if (r_state == S_DECIDE) begin
                unique case (r_op)
                    OP_GET: begin
                        if (r_m_found) begin
                            r_failed <= 1'b0;
                            r_oval   <= r_m_val;
                            r_tgt    <= r_m_idx;
                            r_tgt_rank <= r_m_rank;
                            if (r_m_prot) begin
                                r_kind <= K_TOUCH;
                            end else begin
                                r_kind <= K_PROMOTE;
                                r_aux  <= r_lq_idx;
                                if (r_q_cnt >= CAP && r_lq_found) begin
                                    r_demote <= 1'b1;
                                end else begin
                                    r_p_cnt <= r_p_cnt - CW'(1);
                                    r_q_cnt <= r_q_cnt + CW'(1);
                                    r_pfull <= ((r_p_cnt - CW'(1)) >= CAP);
                                end
                            end
                        end
                    end
                    OP_ADD: begin
                        if (r_p_cnt < CAP && !r_m_found && r_f_found) begin
                            r_failed <= 1'b0;
                            r_kind   <= K_INSERT;
                            r_tgt    <= r_f_idx;
                            r_p_cnt  <= r_p_cnt + CW'(1);
                            r_pfull  <= ((r_p_cnt + CW'(1)) >= CAP);
                        end
                    end
                    OP_UPDATE: begin
                        if (r_m_found) begin
                            r_failed <= 1'b0;
                            r_kind   <= K_REWRITE;
                            r_tgt    <= r_m_idx;
                        end
                    end
                    OP_EVICT: begin
                        if (r_p_cnt >= CAP && r_lp_found) begin
                            r_failed <= 1'b0;
                            r_kind   <= K_DROP;
                            r_tgt    <= r_lp_idx;
                            r_okey   <= r_lp_key;
                            r_oval   <= r_lp_val;
                            r_odirty <= r_lp_dirty;
                            r_p_cnt  <= r_p_cnt - CW'(1);
                            r_pfull  <= ((r_p_cnt - CW'(1)) >= CAP);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign i_req.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = (r_state == S_RESP);
    assign o_rsp.failed          = r_failed;
    assign o_rsp.out_value       = r_oval;
    assign o_rsp.out_key         = r_okey;
    assign o_rsp.out_dirty       = r_odirty;
    assign o_rsp.probation_full  = r_pfull;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request taken while a response word is pending");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_cnt <= CAP) && (r_q_cnt <= CAP))
        else $error("segment count above capacity");

    a_write_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_CLEAR || r_state == S_UPDATE))
        else $error("entry memory written outside clear or update pass");

    a_fail_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> !r_failed)
        else $error("update pass started for a failed request");
endmodule
`default_nettype wire
